// File: design/fir_filter_with_delay_line_unit_macros.svh
// Assertion helpers for the FIR filter RTL.
`ifndef FIR_FILTER_WITH_DELAY_LINE_UNIT_MACROS_SVH
`define FIR_FILTER_WITH_DELAY_LINE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FDL_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fdl: implication check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define FDL_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fdl: next-cycle check failed");

`endif

// File: design/fdl_pkg.sv
`default_nettype none
package fdl_pkg;

    localparam int NUM_TAPS  = 33;
    localparam int SAMPLE_W  = 16;
    localparam int IDX_W     = 6;
    localparam int PROD_W    = 2 * SAMPLE_W;
    localparam int ACC_W     = PROD_W + $clog2(NUM_TAPS) + 1;
    localparam int FRAC_BITS = 15;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic        [IDX_W-1:0]    coef_idx_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [ACC_W-1:0]    acc_t;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_COEF   = 1'b1;

    localparam acc_t ROUND_BIAS = acc_t'(1 << (FRAC_BITS - 1));
    localparam acc_t SAT_MAX    = acc_t'(32767);
    localparam acc_t SAT_MIN    = acc_t'(-32768);

    typedef struct packed {
        logic    shift;
        logic    coef_wr;
        sample_t coef_val;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// File: design/fdl_req_if.sv
`default_nettype none
interface fdl_req_if;
    import fdl_pkg::*;

    logic      valid;
    logic      ready;
    logic      req_type;
    sample_t   sample_in;
    coef_idx_t coef_index;
    sample_t   coef_value;

    modport source (output valid, output req_type, output sample_in,
                    output coef_index, output coef_value, input ready);
    modport sink   (input valid, input req_type, input sample_in,
                    input coef_index, input coef_value, output ready);
endinterface
`default_nettype wire

// File: design/fdl_rsp_if.sv
`default_nettype none
interface fdl_rsp_if;
    import fdl_pkg::*;

    logic    valid;
    logic    ready;
    sample_t filtered_out;
    logic    clipped;

    modport source (output valid, output filtered_out, output clipped, input ready);
    modport sink   (input valid, input filtered_out, input clipped, output ready);
endinterface
`default_nettype wire

// File: design/fir_filter_with_delay_line_unit.sv
// Direct-form FIR filter, NUM_TAPS taps, Q1.15 samples and coefficients.
// req channel: req_type selects a sample item or a coefficient write.
//   A coefficient write loads one tap (index beyond the last tap ignored)
//   and yields no result; writes may follow back to back while req.ready is high.
//   A sample item shifts the delay line and yields one rsp item.
// rsp channel: filtered_out, rounded half up and saturated, with clipped
//   set when saturation changed the value.
// Each tap cell holds one sample and one coefficient and forms its product;
//   a partial sum walks down the row of cells, one cell a cycle.
// A sample item passes start1_reg, start2_reg, the row of cells and
//   pend_valid_reg to the output register. req.ready stays low from sample
//   acceptance until that move, so the next item waits for the last one.
// Results are held in an output register; while the receiver stalls, a
//   finished sum waits in the last cell until the output register frees,
//   and req.ready stays low, so no coefficient write is taken until then.
// Reset clears the delay line and every coefficient to zero.
`default_nettype none
`include "fir_filter_with_delay_line_unit_macros.svh"
module fir_filter_with_delay_line_unit (
    input  wire       clk,
    input  wire       rst_n,
    fdl_req_if.sink   req,
    fdl_rsp_if.source rsp
);
    import fdl_pkg::*;

    logic       req_fire, smp_fire, coef_fire, move;
    logic       busy_reg, busy_next;
    logic       start1_reg, start2_reg;
    logic       pend_valid_reg, pend_valid_next;
    logic       out_valid_reg, out_valid_next;
    sample_t    filtered_reg, filtered_next;
    logic       clipped_reg, clipped_next;
    acc_t       rnd, quo;

    cell_ctrl_t ctrl   [NUM_TAPS];
    sample_t    x_chain[1:NUM_TAPS-1];
    sample_t    x_feed [NUM_TAPS];
    logic       tok    [NUM_TAPS];
    acc_t       acc    [NUM_TAPS];

    assign req.ready = !busy_reg;
    assign req_fire  = req.valid && !busy_reg;
    assign smp_fire  = req_fire && (req.req_type == REQ_SAMPLE);
    assign coef_fire = req_fire && (req.req_type == REQ_COEF);
    assign move      = pend_valid_reg && (!out_valid_reg || rsp.ready);

    for (genvar i = 0; i < NUM_TAPS; i++)
    begin : g_cell
        assign ctrl[i].shift    = smp_fire;
        assign ctrl[i].coef_wr  = coef_fire && (req.coef_index == IDX_W'(i));
        assign ctrl[i].coef_val = req.coef_value;

        if (i == NUM_TAPS - 1)
        begin : g_newest
            assign x_feed[i] = req.sample_in;
        end
        else
        begin : g_inner
            assign x_feed[i] = x_chain[i+1];
        end

        if (i == 0)
        begin : g_first
            fdl_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (ctrl[i]),
                .x_in    (x_feed[i]),
                .x_out   (),
                .tok_in  (start2_reg),
                .acc_in  ('0),
                .tok_out (tok[i]),
                .acc_out (acc[i])
            );
        end
        else
        begin : g_rest
            fdl_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (ctrl[i]),
                .x_in    (x_feed[i]),
                .x_out   (x_chain[i]),
                .tok_in  (tok[i-1]),
                .acc_in  (acc[i-1]),
                .tok_out (tok[i]),
                .acc_out (acc[i])
            );
        end
    end

    // round half up, then saturate
    always_comb
    begin
        rnd = acc[NUM_TAPS-1] + ROUND_BIAS;
        quo = rnd >>> FRAC_BITS;
        if (quo > SAT_MAX)
        begin
            filtered_next = SAMPLE_W'(SAT_MAX);
            clipped_next  = 1'b1;
        end
        else if (quo < SAT_MIN)
        begin
            filtered_next = SAMPLE_W'(SAT_MIN);
            clipped_next  = 1'b1;
        end
        else
        begin
            filtered_next = SAMPLE_W'(quo);
            clipped_next  = 1'b0;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (smp_fire)
            busy_next = 1'b1;
        else if (move)
            busy_next = 1'b0;

        pend_valid_next = pend_valid_reg;
        if (tok[NUM_TAPS-1])
            pend_valid_next = 1'b1;
        else if (move)
            pend_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (move)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            start1_reg     <= 1'b0;
            start2_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            start1_reg     <= smp_fire;
            start2_reg     <= start1_reg;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            filtered_reg <= filtered_next;
            clipped_reg  <= clipped_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.filtered_out = filtered_reg;
    assign rsp.clipped      = clipped_reg;

    `FDL_ASSERT_NXT(a_busy_after_sample, smp_fire, busy_reg && start1_reg)
    `FDL_ASSERT_IMP(a_sum_only_when_busy, tok[NUM_TAPS-1], busy_reg && !pend_valid_reg)
    `FDL_ASSERT_IMP(a_pend_only_when_busy, pend_valid_reg, busy_reg && !req.ready)
    `FDL_ASSERT_IMP(a_start_only_when_busy, start1_reg || start2_reg, busy_reg)
endmodule
`default_nettype wire

// File: design/fdl_cell.sv
`default_nettype none
module fdl_cell (
    input  wire                 clk,
    input  wire                 rst_n,
    input  fdl_pkg::cell_ctrl_t ctrl,
    input  fdl_pkg::sample_t    x_in,
    output fdl_pkg::sample_t    x_out,
    input  wire                 tok_in,
    input  fdl_pkg::acc_t       acc_in,
    output logic                tok_out,
    output fdl_pkg::acc_t       acc_out
);
    import fdl_pkg::*;

    sample_t x_reg, x_next;
    sample_t coef_reg, coef_next;
    prod_t   prod_reg, prod_next;
    logic    tok_reg;
    acc_t    acc_reg, acc_next;

    always_comb
    begin
        x_next    = ctrl.shift   ? x_in          : x_reg;
        coef_next = ctrl.coef_wr ? ctrl.coef_val : coef_reg;
        prod_next = x_reg * coef_reg;
        acc_next  = tok_in ? (acc_in + ACC_W'(prod_reg)) : acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg    <= '0;
            coef_reg <= '0;
            tok_reg  <= 1'b0;
        end
        else
        begin
            x_reg    <= x_next;
            coef_reg <= coef_next;
            tok_reg  <= tok_in;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign x_out   = x_reg;
    assign tok_out = tok_reg;
    assign acc_out = acc_reg;
endmodule
`default_nettype wire
